// ===== hdl/kgd_pkg.sv =====
// types, constants and register codes shared by the grid density pipeline
// no dependencies
`default_nettype none

package kgd_pkg;

	localparam int GRID_SIZE = 4096;
	localparam int BOX_SIDE  = 256;

	localparam int CELL_W    = 13;
	localparam int CFG_IDX_W = 4;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROJ_XX    = 4'd0,
		CFG_PROJ_XY    = 4'd1,
		CFG_PROJ_YX    = 4'd2,
		CFG_PROJ_YY    = 4'd3,
		CFG_PROJ_OFF_X = 4'd4,
		CFG_PROJ_OFF_Y = 4'd5,
		CFG_INV_BW_SQ  = 4'd6,
		CFG_PEAK_SCALE = 4'd7
	} kgd_cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] pc_x;
		logic signed [31:0] pc_y;
		logic [11:0]        corner_x;
		logic [11:0]        corner_y;
		logic [7:0]         step_i;
		logic [7:0]         step_j;
		logic [8:0]         row_count;
		logic [23:0]        base_position;
	} kgd_in_t;

	typedef struct packed {
		logic [31:0] density;
		logic [23:0] device_position;
		logic [11:0] host_cell_x;
		logic [11:0] host_cell_y;
	} kgd_out_t;

	// fields that ride along beside the density math
	typedef struct packed {
		logic [23:0] device_position;
		logic [11:0] host_cell_x;
		logic [11:0] host_cell_y;
	} kgd_side_t;

	typedef struct packed {
		logic signed [31:0] proj_xx;
		logic signed [31:0] proj_xy;
		logic signed [31:0] proj_yx;
		logic signed [31:0] proj_yy;
		logic signed [31:0] proj_off_x;
		logic signed [31:0] proj_off_y;
		logic [31:0]        inv_bw_sq;
		logic [31:0]        peak_scale;
	} kgd_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/kgd_cfg_regs.sv =====
// configuration register file for the grid density pipeline
// depends on kgd_pkg
`default_nettype none

module kgd_cfg_regs (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [kgd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [31:0]                      cfg_data,
	output kgd_pkg::kgd_cfg_t               cfg
);
	import kgd_pkg::*;

	kgd_cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg       = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.proj_xx    <= 32'sh0001_0000;
			regs_q.proj_xy    <= 32'sh0;
			regs_q.proj_yx    <= 32'sh0;
			regs_q.proj_yy    <= 32'sh0001_0000;
			regs_q.proj_off_x <= 32'sh0;
			regs_q.proj_off_y <= 32'sh0;
			regs_q.inv_bw_sq  <= 32'h0001_0000;
			regs_q.peak_scale <= 32'h0001_0000;
		end else if (cfg_valid && cfg_ready) begin
			case (kgd_cfg_idx_t'(cfg_index))
				CFG_PROJ_XX:    regs_q.proj_xx    <= $signed(cfg_data);
				CFG_PROJ_XY:    regs_q.proj_xy    <= $signed(cfg_data);
				CFG_PROJ_YX:    regs_q.proj_yx    <= $signed(cfg_data);
				CFG_PROJ_YY:    regs_q.proj_yy    <= $signed(cfg_data);
				CFG_PROJ_OFF_X: regs_q.proj_off_x <= $signed(cfg_data);
				CFG_PROJ_OFF_Y: regs_q.proj_off_y <= $signed(cfg_data);
				CFG_INV_BW_SQ:  regs_q.inv_bw_sq  <= cfg_data;
				CFG_PEAK_SCALE: regs_q.peak_scale <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/kgd_project.sv =====
// stages 1-4: grid cell, projection into pc space, clamped distance magnitudes
// depends on kgd_pkg
`default_nettype none

module kgd_project (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  kgd_pkg::kgd_in_t     in_item,
	input  kgd_pkg::kgd_cfg_t    cfg,
	output logic                 out_valid,
	output logic [31:0]          ax,
	output logic [31:0]          ay,
	output kgd_pkg::kgd_side_t   out_side
);
	import kgd_pkg::*;

	localparam logic [CELL_W-1:0] STEP_MAX = CELL_W'(BOX_SIDE - 1);
	localparam logic [16:0]       CELL_MAX = 17'(GRID_SIZE - 1);
	localparam logic [48:0]       MAG_MAX  = 49'h0_8000_0000;

	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1
	logic [7:0]          si_c, sj_c;
	logic [CELL_W-1:0]   cx, cy;
	logic [16:0]         row_prod;
	kgd_side_t           side_c;

	logic signed [31:0]  pcx_s1, pcy_s1;
	logic [CELL_W-1:0]   cx_s1, cy_s1;
	kgd_side_t           side_s1;

	// stage 2
	logic signed [CELL_W+32:0] mxx_s2, mxy_s2, myx_s2, myy_s2;
	logic signed [31:0]        pcx_s2, pcy_s2;
	kgd_side_t                 side_s2;

	// stage 3
	logic signed [47:0]  px_s3, py_s3;
	logic signed [31:0]  pcx_s3, pcy_s3;
	kgd_side_t           side_s3;

	// stage 4
	logic signed [48:0]  dx, dy;
	logic [48:0]         mag_x, mag_y;
	logic [31:0]         ax_s4, ay_s4;
	kgd_side_t           side_s4;

	always_comb begin
		si_c = ({5'b0, in_item.step_i} > STEP_MAX) ? STEP_MAX[7:0] : in_item.step_i;
		sj_c = ({5'b0, in_item.step_j} > STEP_MAX) ? STEP_MAX[7:0] : in_item.step_j;
		cx   = {1'b0, in_item.corner_x} + {5'b0, si_c};
		cy   = {1'b0, in_item.corner_y} + {5'b0, sj_c};
		row_prod = in_item.row_count * si_c;
		side_c.device_position = in_item.base_position + {7'b0, row_prod} + {16'b0, sj_c};
		side_c.host_cell_x = ({4'b0, cx} > CELL_MAX) ? CELL_MAX[11:0] : cx[11:0];
		side_c.host_cell_y = ({4'b0, cy} > CELL_MAX) ? CELL_MAX[11:0] : cy[11:0];
	end

	// distance magnitudes, clamped at 2^31 which is already outside support
	always_comb begin
		dx    = 49'(pcx_s3) - 49'(px_s3);
		dy    = 49'(pcy_s3) - 49'(py_s3);
		mag_x = dx[48] ? 49'(-dx) : 49'(dx);
		mag_y = dy[48] ? 49'(-dy) : 49'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pcx_s1  <= in_item.pc_x;
		pcy_s1  <= in_item.pc_y;
		cx_s1   <= cx;
		cy_s1   <= cy;
		side_s1 <= side_c;

		mxx_s2  <= cfg.proj_xx * $signed({1'b0, cx_s1});
		mxy_s2  <= cfg.proj_xy * $signed({1'b0, cy_s1});
		myx_s2  <= cfg.proj_yx * $signed({1'b0, cx_s1});
		myy_s2  <= cfg.proj_yy * $signed({1'b0, cy_s1});
		pcx_s2  <= pcx_s1;
		pcy_s2  <= pcy_s1;
		side_s2 <= side_s1;

		px_s3   <= 48'(mxx_s2) + 48'(mxy_s2) + 48'(cfg.proj_off_x);
		py_s3   <= 48'(myx_s2) + 48'(myy_s2) + 48'(cfg.proj_off_y);
		pcx_s3  <= pcx_s2;
		pcy_s3  <= pcy_s2;
		side_s3 <= side_s2;

		ax_s4   <= (mag_x > MAG_MAX) ? MAG_MAX[31:0] : mag_x[31:0];
		ay_s4   <= (mag_y > MAG_MAX) ? MAG_MAX[31:0] : mag_y[31:0];
		side_s4 <= side_s3;
	end

	assign out_valid = v_s4;
	assign ax        = ax_s4;
	assign ay        = ay_s4;
	assign out_side  = side_s4;

endmodule

`default_nettype wire

// ===== hdl/kgd_kernel.sv =====
// stages 5-9: squared distance, bandwidth scaling and epanechnikov profile
// depends on kgd_pkg
`default_nettype none

module kgd_kernel (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire [31:0]           ax,
	input  wire [31:0]           ay,
	input  kgd_pkg::kgd_side_t   in_side,
	input  kgd_pkg::kgd_cfg_t    cfg,
	output logic                 out_valid,
	output kgd_pkg::kgd_out_t    out_item
);
	import kgd_pkg::*;

	logic v_s5, v_s6, v_s7, v_s8, v_s9;

	logic [63:0] sqx_s5, sqy_s5;
	kgd_side_t   side_s5;

	logic [63:0] sum;
	logic [47:0] d2;
	logic [31:0] d2_s6;
	logic        big_s6;
	kgd_side_t   side_s6;

	logic [63:0] t_s7;
	logic        big_s7;
	kgd_side_t   side_s7;

	logic [47:0] temp;
	logic        in_support;
	logic [16:0] sub;
	logic [16:0] sub_s8;
	logic        in_support_s8;
	kgd_side_t   side_s8;

	logic [48:0] dens_prod;
	logic [31:0] dens;
	kgd_out_t    out_s9;

	assign sum = sqx_s5 + sqy_s5;
	assign d2  = sum[63:16];

	always_comb begin
		temp   = t_s7[63:16];
		// zero bandwidth register means every point is at the kernel peak
		in_support = (cfg.inv_bw_sq == 32'h0) || (!big_s7 && (temp < 48'(ONE_Q16)));
		sub    = (cfg.inv_bw_sq == 32'h0) ? ONE_Q16 : (ONE_Q16 - temp[16:0]);
	end

	always_comb begin
		dens_prod = cfg.peak_scale * sub_s8;
		dens      = dens_prod[48] ? 32'hFFFF_FFFF : dens_prod[47:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s5 <= in_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s5  <= ax * ax;
		sqy_s5  <= ay * ay;
		side_s5 <= in_side;

		d2_s6   <= d2[31:0];
		big_s6  <= |d2[47:32];
		side_s6 <= side_s5;

		t_s7    <= d2_s6 * cfg.inv_bw_sq;
		big_s7  <= big_s6;
		side_s7 <= side_s6;

		sub_s8        <= sub;
		in_support_s8 <= in_support;
		side_s8       <= side_s7;

		out_s9.density         <= in_support_s8 ? dens : 32'h0;
		out_s9.device_position <= side_s8.device_position;
		out_s9.host_cell_x     <= side_s8.host_cell_x;
		out_s9.host_cell_y     <= side_s8.host_cell_y;
	end

	assign out_valid = v_s9;
	assign out_item  = out_s9;

	// a point outside the support leaves as zero density
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && !in_support_s8) |=> (out_s9.density == 32'h0))
		else $error("outside point gave nonzero density");

	// far distances never count as in support unless the bandwidth register is zero
	a_big_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && big_s7 && (cfg.inv_bw_sq != 32'h0)) |=> !in_support_s8)
		else $error("overflowed distance treated as in support");

endmodule

`default_nettype wire

// ===== hdl/kde_grid_density_2d.sv =====
// 2d epanechnikov density at one grid point, nine-stage pipeline
// depends on kgd_pkg, kgd_cfg_regs, kgd_project and kgd_kernel
// throughput: one point per cycle, set by the fully pipelined multipliers
// busy is always low, results cannot be stalled and leave on done
// reset clears the valid bits and loads the register reset values
`default_nettype none

module kde_grid_density_2d (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           busy,
	input  kgd_pkg::kgd_in_t               item,
	output logic                           done,
	output kgd_pkg::kgd_out_t              result,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [kgd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [31:0]                     cfg_data
);
	import kgd_pkg::*;

	kgd_cfg_t  cfg;
	logic      proj_valid;
	logic [31:0] ax, ay;
	kgd_side_t proj_side;
	logic      accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	kgd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kgd_project u_project (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_item   (item),
		.cfg       (cfg),
		.out_valid (proj_valid),
		.ax        (ax),
		.ay        (ay),
		.out_side  (proj_side)
	);

	kgd_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (proj_valid),
		.ax        (ax),
		.ay        (ay),
		.in_side   (proj_side),
		.cfg       (cfg),
		.out_valid (done),
		.out_item  (result)
	);

	// every start transfer comes out on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##9 done)
		else $error("start transfer without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 9))
		else $error("result without start transfer");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench for kde_grid_density_2d: directed and random grid points against a density predictor
// depends on hdl/kgd_pkg.sv and hdl/kde_grid_density_2d.sv
`timescale 1ns / 100ps

module tb;
	import kgd_pkg::*;

	class density_tracker;
		kgd_cfg_t regs;
		kgd_out_t due[$];
		int faults;

		function void load_defaults();
			regs = '0;
			regs.proj_xx    = 32'(ONE_Q16);
			regs.proj_yy    = 32'(ONE_Q16);
			regs.inv_bw_sq  = 32'(ONE_Q16);
			regs.peak_scale = 32'(ONE_Q16);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				CFG_PROJ_XX:    regs.proj_xx    = val;
				CFG_PROJ_XY:    regs.proj_xy    = val;
				CFG_PROJ_YX:    regs.proj_yx    = val;
				CFG_PROJ_YY:    regs.proj_yy    = val;
				CFG_PROJ_OFF_X: regs.proj_off_x = val;
				CFG_PROJ_OFF_Y: regs.proj_off_y = val;
				CFG_INV_BW_SQ:  regs.inv_bw_sq  = val;
				CFG_PEAK_SCALE: regs.peak_scale = val;
				default: ;
			endcase
		endfunction

		// grid cell in principal space, using the unsaturated cell
		function void project(kgd_in_t p, output longint px, output longint py,
				output longint cx, output longint cy);
			logic [7:0] si, sj;
			si = (p.step_i > BOX_SIDE - 1) ? 8'(BOX_SIDE - 1) : p.step_i;
			sj = (p.step_j > BOX_SIDE - 1) ? 8'(BOX_SIDE - 1) : p.step_j;
			cx = longint'(p.corner_x) + longint'(si);
			cy = longint'(p.corner_y) + longint'(sj);
			px = longint'(regs.proj_xx) * cx + longint'(regs.proj_xy) * cy
				+ longint'(regs.proj_off_x);
			py = longint'(regs.proj_yx) * cx + longint'(regs.proj_yy) * cy
				+ longint'(regs.proj_off_y);
		endfunction

		function kgd_out_t predict_point(kgd_in_t p);
			kgd_out_t r;
			longint px, py, cx, cy, dx, dy;
			bit [63:0] ax, ay, d2, temp, dens, pos;
			bit in_support;
			project(p, px, py, cx, cy);
			dx = longint'(p.pc_x) - px;
			dy = longint'(p.pc_y) - py;
			ax = (dx < 0) ? 64'(-dx) : 64'(dx);
			ay = (dy < 0) ? 64'(-dy) : 64'(dy);
			// magnitudes past 2^31 are out of support anyway
			if (ax > 64'h8000_0000) ax = 64'h8000_0000;
			if (ay > 64'h8000_0000) ay = 64'h8000_0000;
			d2 = (ax * ax + ay * ay) >> 16;
			temp = 0;
			if (regs.inv_bw_sq == 0)
				in_support = 1'b1;
			else if (d2 >= 64'h1_0000_0000)
				in_support = 1'b0;
			else begin
				temp = (d2 * 64'(regs.inv_bw_sq)) >> 16;
				in_support = (temp < 64'(ONE_Q16));
			end
			dens = in_support ? ((64'(regs.peak_scale) * (64'(ONE_Q16) - temp)) >> 16)
				: 64'd0;
			if (dens > 64'hFFFF_FFFF) dens = 64'hFFFF_FFFF;
			pos = 64'(p.base_position) + 64'(p.row_count) * 64'(cx - longint'(p.corner_x))
				+ 64'(cy - longint'(p.corner_y));
			r.density         = dens[31:0];
			r.device_position = pos[23:0];
			r.host_cell_x     = (cx > GRID_SIZE - 1) ? 12'(GRID_SIZE - 1) : 12'(cx);
			r.host_cell_y     = (cy > GRID_SIZE - 1) ? 12'(GRID_SIZE - 1) : 12'(cy);
			return r;
		endfunction

		function void note_point(kgd_in_t p);
			due.push_back(predict_point(p));
		endfunction

		function void check_point(kgd_out_t got);
			kgd_out_t want;
			if (due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: density %h position %h cell %h,%h",
						got.density, got.device_position, got.host_cell_x,
						got.host_cell_y);
				return;
			end
			want = due.pop_front();
			if (got.density !== want.density
					|| got.device_position !== want.device_position
					|| got.host_cell_x !== want.host_cell_x
					|| got.host_cell_y !== want.host_cell_y) begin
				faults++;
				if (faults <= 10)
					$display("mismatch: density exp %h got %h, ", want.density,
						got.density, "position exp %h got %h, ",
						want.device_position, got.device_position,
						"cell exp %h,%h got %h,%h", want.host_cell_x,
						want.host_cell_y, got.host_cell_x, got.host_cell_y);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	kgd_in_t item;
	logic done;
	kgd_out_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	density_tracker sb;
	int points_taken = 0;
	int regs_taken = 0;

	kde_grid_density_2d DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

	// results are checked before the same edge's input transfer is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_point(result);
			if (start && !busy) begin
				sb.note_point(item);
				points_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				sb.set_reg(cfg_index, cfg_data);
				regs_taken++;
			end
		end
	end

	// all driving tasks enter and leave on a falling edge
	task automatic send_point(kgd_in_t p);
		int target;
		target = points_taken + 1;
		start = 1'b1;
		item  = p;
		do @(negedge clk); while (points_taken < target);
	endtask

	task automatic pause_sender(int n);
		if (n > 0) begin
			start = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		start = 1'b0;
		while (sb.due.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		int target;
		target = regs_taken + 1;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(negedge clk); while (regs_taken < target);
		cfg_valid = 1'b0;
		repeat ($urandom_range(0, 2)) @(negedge clk);
	endtask

	task automatic apply_setting(kgd_cfg_t c);
		write_reg(CFG_PROJ_XX, c.proj_xx);
		write_reg(CFG_PROJ_XY, c.proj_xy);
		write_reg(CFG_PROJ_YX, c.proj_yx);
		write_reg(CFG_PROJ_YY, c.proj_yy);
		write_reg(CFG_PROJ_OFF_X, c.proj_off_x);
		write_reg(CFG_PROJ_OFF_Y, c.proj_off_y);
		write_reg(CFG_INV_BW_SQ, c.inv_bw_sq);
		write_reg(CFG_PEAK_SCALE, c.peak_scale);
	endtask

	function automatic kgd_in_t make_point(logic [31:0] pcx, logic [31:0] pcy,
			logic [11:0] cx, logic [11:0] cy, logic [7:0] si, logic [7:0] sj,
			logic [8:0] rows, logic [23:0] base);
		kgd_in_t p;
		p.pc_x          = pcx;
		p.pc_y          = pcy;
		p.corner_x      = cx;
		p.corner_y      = cy;
		p.step_i        = si;
		p.step_j        = sj;
		p.row_count     = rows;
		p.base_position = base;
		return p;
	endfunction

	initial begin
		kgd_cfg_t cfg;
		kgd_in_t p;
		longint px, py, cx, cy;
		int reach, dx, dy, r, ph, n;
		real theta, sx, sy, h;
		bit calm;

		sb = new;
		sb.load_defaults();
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PROJ_XX;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset setting: identity projection, unit bandwidth and peak
		send_point(make_point(32'(13 << 16), 32'(24 << 16), 12'd10, 12'd20, 8'd3, 8'd4,
			9'd256, 24'd0));
		send_point(make_point(32'((13 << 16) + 16'hFFFF), 32'(24 << 16), 12'd10, 12'd20,
			8'd3, 8'd4, 9'd1, 24'd100));
		// distance of exactly one bandwidth is just outside
		send_point(make_point(32'(14 << 16), 32'(24 << 16), 12'd10, 12'd20, 8'd3, 8'd4,
			9'd2, 24'd0));
		send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd10, 12'd20, 8'd3, 8'd4,
			9'd511, 24'hFF_FFFF));
		send_point(make_point(32'h8000_0000, 32'h8000_0000, 12'd0, 12'd0, 8'd0, 8'd0,
			9'd0, 24'd0));
		// host cell saturates, projection does not
		send_point(make_point(32'(4350 << 16), 32'(4350 << 16), 12'hFFF, 12'hFFF, 8'hFF,
			8'hFF, 9'h1FF, 24'hFF_FFFF));
		send_point(make_point(32'd0, 32'd0, 12'd0, 12'd0, 8'd0, 8'd0, 9'd0, 24'd0));
		send_point(make_point(32'hFFFF_FFFF, 32'd0, 12'd0, 12'd0, 8'hFF, 8'd0, 9'd256,
			24'hFF_FFFF));
		send_point(make_point(32'(4000 << 16), 32'(100 << 16), 12'd3990, 12'd90, 8'd10,
			8'd10, 9'd1, 24'hFF_FF00));
		send_point(make_point(32'h0000_8000, 32'hFFFF_8000, 12'd0, 12'd0, 8'd0, 8'd0,
			9'd300, 24'h80_0000));
		drain();

		// zero bandwidth register gives the peak everywhere
		write_reg(CFG_INV_BW_SQ, 32'd0);
		write_reg(CFG_PEAK_SCALE, 32'hFFFF_FFFF);
		send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 12'd0, 12'hFFF, 8'd0, 8'hFF,
			9'd7, 24'd5));
		send_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 12'hFFF, 12'd0, 8'hFF, 8'd0,
			9'd128, 24'd0));
		drain();

		cfg.proj_xx    = 32'h7FFF_FFFF;
		cfg.proj_xy    = 32'h7FFF_FFFF;
		cfg.proj_yx    = 32'h7FFF_FFFF;
		cfg.proj_yy    = 32'h7FFF_FFFF;
		cfg.proj_off_x = 32'h7FFF_FFFF;
		cfg.proj_off_y = 32'h7FFF_FFFF;
		cfg.inv_bw_sq  = 32'hFFFF_FFFF;
		cfg.peak_scale = 32'hFFFF_FFFF;
		apply_setting(cfg);
		send_point(make_point(32'h8000_0000, 32'h8000_0000, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF,
			9'h1FF, 24'hFF_FFFF));
		send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd0, 12'd0, 8'd0, 8'd0,
			9'd1, 24'd0));
		drain();

		cfg.proj_xx    = 32'h8000_0000;
		cfg.proj_xy    = 32'h8000_0000;
		cfg.proj_yx    = 32'h8000_0000;
		cfg.proj_yy    = 32'h8000_0000;
		cfg.proj_off_x = 32'h8000_0000;
		cfg.proj_off_y = 32'h8000_0000;
		apply_setting(cfg);
		send_point(make_point(32'h8000_0000, 32'h8000_0000, 12'd0, 12'd0, 8'd0, 8'd0,
			9'd0, 24'd0));
		send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF,
			9'd256, 24'hAB_CDEF));
		drain();

		// smallest nonzero bandwidth factor with a far but in-range distance
		cfg.proj_xx    = 32'(ONE_Q16);
		cfg.proj_xy    = 32'd0;
		cfg.proj_yx    = 32'd0;
		cfg.proj_yy    = 32'(ONE_Q16);
		cfg.proj_off_x = 32'd0;
		cfg.proj_off_y = 32'd0;
		cfg.inv_bw_sq  = 32'd1;
		cfg.peak_scale = 32'hFFFF_FFFF;
		apply_setting(cfg);
		send_point(make_point(32'(210 << 16), 32'(20 << 16), 12'd10, 12'd20, 8'd0, 8'd0,
			9'd16, 24'd0));
		send_point(make_point(32'h8000_0000, 32'd0, 12'hFFF, 12'd0, 8'hFF, 8'd0, 9'd16,
			24'd0));
		drain();

		// unknown register indexes must leave the setting untouched
		write_reg(CFG_IDX_W'(CFG_PEAK_SCALE + 1), 32'd0);
		write_reg(CFG_IDX_W'(CFG_PEAK_SCALE + 8), 32'hDEAD_BEEF);
		send_point(make_point(32'(30 << 16), 32'(40 << 16), 12'd30, 12'd40, 8'd0, 8'd0,
			9'd3, 24'd9));
		send_point(make_point(32'(31 << 16), 32'(40 << 16), 12'd30, 12'd40, 8'd0, 8'd0,
			9'd3, 24'd9));
		drain();

		for (ph = 0; ph < 8; ph++) begin
			// rotated and scaled projection, bandwidth from a quarter to eight units
			theta = real'($urandom_range(0, 359)) * 3.14159265 / 180.0;
			sx = real'($urandom_range(25, 200)) / 100.0;
			sy = real'($urandom_range(25, 200)) / 100.0;
			h  = real'($urandom_range(25, 800)) / 100.0;
			cfg.proj_xx    = $rtoi($cos(theta) * sx * 65536.0);
			cfg.proj_xy    = $rtoi(-$sin(theta) * sy * 65536.0);
			cfg.proj_yx    = $rtoi($sin(theta) * sx * 65536.0);
			cfg.proj_yy    = $rtoi($cos(theta) * sy * 65536.0);
			cfg.proj_off_x = int'($urandom_range(0, 134217728)) - 67108864;
			cfg.proj_off_y = int'($urandom_range(0, 134217728)) - 67108864;
			cfg.inv_bw_sq  = $rtoi(65536.0 / (h * h));
			cfg.peak_scale = $urandom_range(0, 1) ? $urandom : 32'(41721 + $urandom_range(0, 2000));
			if (ph == 3) cfg.inv_bw_sq = 32'd0;
			if (ph == 6) cfg.peak_scale = 32'hFFFF_FFFF;
			reach = $rtoi(h * 65536.0 * 1.3);
			// the setting only changes with the pipeline empty
			drain();
			apply_setting(cfg);

			for (n = 0; n < 104; n++) begin
				if (n % 26 == 0) calm = ($urandom_range(0, 3) == 0);
				if (n == 52 && ph % 2 == 1) drain();
				p.corner_x      = 12'($urandom_range(0, 4095));
				p.corner_y      = 12'($urandom_range(0, 4095));
				p.step_i        = 8'($urandom_range(0, 255));
				p.step_j        = 8'($urandom_range(0, 255));
				p.base_position = 24'($urandom_range(0, 24'hFF_FFFF));
				if ($urandom_range(0, 4) == 0) begin
					p.pc_x      = $urandom;
					p.pc_y      = $urandom;
					p.row_count = 9'($urandom_range(0, 511));
				end else begin
					// aim near the projected cell so the kernel support is exercised
					p.row_count = 9'($urandom_range(1, 256));
					sb.project(p, px, py, cx, cy);
					dx = int'($urandom_range(0, 2 * reach)) - reach;
					dy = int'($urandom_range(0, 2 * reach)) - reach;
					p.pc_x = 32'(px + dx);
					p.pc_y = 32'(py + dy);
				end
				send_point(p);
				if (!calm) begin
					r = $urandom_range(0, 99);
					pause_sender((r < 50) ? 0 : (r < 88) ? $urandom_range(1, 3)
						: $urandom_range(8, 40));
				end
			end
		end

		drain();
		repeat (8) @(negedge clk);
		sb.faults += sb.due.size();
		if (sb.faults == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
